[rtl/jitl_pkg.sv]
`timescale 1ns / 1ps
// Package for the joint impedance torque law: sizes, fixed-point constants,
// register and request codes, and the 32-bit saturation helper. No dependencies.
package jitl_pkg;

  localparam int NUM_JOINTS = 7;
  localparam int JointIdxW  = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam int JointW     = 3;
  localparam int CfgIdxW    = 2;
  localparam int StepW      = 31;

  // filter weights in Q16.16: 0.01 on the old value, 0.99 on the new sample
  localparam int AlphaOldQ16 = 655;
  localparam int AlphaNewQ16 = 64881;
  localparam int RoundHalf   = 32768;
  localparam int FracW       = 16;

  localparam logic signed [31:0] CoriolisScaleRst = 32'sd65536;
  localparam logic [StepW-1:0]   MaxTorqueStepRst = 31'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCoriolisScale = 2'd0,
    CfgMaxTorqueStep = 2'd1,
    CfgImpedanceOff  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    ReqTarget = 1'b0,
    ReqSample = 1'b1
  } req_type_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/joint_impedance_torque_law.sv]
`timescale 1ns / 1ps
// A control sample's torque command reaches the outputs through the input,
// error, product, sum and output registers, in that order.
// Throughput: one item per cycle; all stages stall together only while a result
// waits on out_ready_i. Target writes and out-of-range joints give no result.
// Reset (rst_ni low, async): pipeline empty, filter and target state zero,
// target-seen clear, registers at coriolis_scale 1.0, max_torque_step 1.0, gains on.
// Depends on jitl_pkg.
module joint_impedance_torque_law (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jitl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [jitl_pkg::JointW-1:0]    joint_index_i,
  input  logic signed [31:0]             target_position_i,
  input  logic signed [31:0]             measured_position_i,
  input  logic signed [31:0]             measured_velocity_i,
  input  logic signed [31:0]             reference_position_i,
  input  logic signed [31:0]             reference_velocity_i,
  input  logic signed [31:0]             coriolis_torque_i,
  input  logic signed [31:0]             last_desired_torque_i,
  input  logic [31:0]                    stiffness_gain_i,
  input  logic [31:0]                    damping_gain_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [jitl_pkg::JointW-1:0]    result_joint_o,
  output logic signed [31:0]             torque_command_o
);

  localparam int TermW = 50;
  localparam int SumW  = 52;

  // configuration
  logic signed [31:0]              coriolis_scale_q;
  logic [jitl_pkg::StepW-1:0]      max_torque_step_q;
  logic                            impedance_off_q;

  // per-joint state, and the single target-seen flag shared by all joints
  logic signed [31:0]              fv_q  [jitl_pkg::NUM_JOINTS];
  logic signed [31:0]              tgt_q [jitl_pkg::NUM_JOINTS];
  logic                            target_seen_q;

  // stage 0: input register
  logic                            s0_valid_q;
  logic                            s0_req_q;
  logic [jitl_pkg::JointW-1:0]     s0_joint_q;
  logic signed [31:0]              s0_tgt_q, s0_q_q, s0_dq_q, s0_qref_q, s0_dqref_q;
  logic signed [31:0]              s0_cor_q, s0_last_q;
  logic [31:0]                     s0_k_q, s0_d_q;

  // stage 1: errors
  logic                            s1_valid_q;
  logic [jitl_pkg::JointW-1:0]     s1_joint_q;
  logic signed [31:0]              s1_ep_q, s1_ev_q, s1_cor_q, s1_last_q;
  logic [31:0]                     s1_k_q, s1_d_q;

  // stage 2: rounded products
  logic                            s2_valid_q;
  logic [jitl_pkg::JointW-1:0]     s2_joint_q;
  logic signed [TermW-1:0]         s2_tc_q, s2_tk_q, s2_td_q;
  logic signed [31:0]              s2_last_q;

  // stage 3: saturated torque
  logic                            s3_valid_q;
  logic [jitl_pkg::JointW-1:0]     s3_joint_q;
  logic signed [31:0]              s3_tau_q, s3_last_q;

  // output register
  logic                            out_valid_q;
  logic [jitl_pkg::JointW-1:0]     out_joint_q;
  logic signed [31:0]              out_tau_q;

  logic                            adv;
  logic                            s0_jok;
  logic [jitl_pkg::JointIdxW-1:0]  s0_idx;
  logic signed [31:0]              fv_old, tgt_old;
  logic signed [49:0]              filt_acc;
  logic signed [31:0]              fv_new;
  logic signed [31:0]              ep_t, ev_t, ep_r, ev_r, ep_d, ev_d;
  logic [31:0]                     k_d, d_d;
  logic                            s1_valid_d;

  logic signed [63:0]              prod_c;
  logic signed [64:0]              prod_k, prod_d;
  logic signed [TermW-1:0]         tc_d, tk_d, td_d;
  logic signed [SumW-1:0]          sum;
  logic signed [31:0]              tau_d;

  logic signed [32:0]              diff, step, diff_c;
  logic signed [31:0]              cmd_d;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  // ---------------- stage 0 logic: filter and errors
  assign s0_jok = ({2'b00, s0_joint_q} < 5'(jitl_pkg::NUM_JOINTS));
  assign s0_idx = jitl_pkg::JointIdxW'(s0_joint_q);

  always_comb begin
    fv_old   = s0_jok ? fv_q[s0_idx]  : 32'sd0;
    tgt_old  = s0_jok ? tgt_q[s0_idx] : 32'sd0;
    filt_acc = 50'(fv_old) * 50'(jitl_pkg::AlphaOldQ16)
             + 50'(s0_dq_q) * 50'(jitl_pkg::AlphaNewQ16)
             + 50'(jitl_pkg::RoundHalf);
    fv_new   = jitl_pkg::sat32(66'(filt_acc >>> jitl_pkg::FracW));
    ep_t     = jitl_pkg::sat32(66'(33'(tgt_old) - 33'(s0_q_q)));
    ev_t     = jitl_pkg::sat32(66'(33'(ep_t) - 33'(fv_new)));
    ep_r     = jitl_pkg::sat32(66'(33'(s0_qref_q) - 33'(s0_q_q)));
    ev_r     = jitl_pkg::sat32(66'(33'(s0_dqref_q) - 33'(fv_new)));
    ep_d     = target_seen_q ? ep_t : ep_r;
    ev_d     = target_seen_q ? ev_t : ev_r;
    k_d      = impedance_off_q ? 32'd0 : s0_k_q;
    d_d      = impedance_off_q ? 32'd0 : s0_d_q;
    s1_valid_d = s0_valid_q && s0_jok && (s0_req_q == jitl_pkg::ReqSample);
  end

  // ---------------- stage 1 logic: products, rounded back to Q16.16
  always_comb begin
    prod_c = 64'(s1_cor_q) * 64'(coriolis_scale_q);
    prod_k = $signed({1'b0, s1_k_q}) * 65'(s1_ep_q);
    prod_d = $signed({1'b0, s1_d_q}) * 65'(s1_ev_q);
    tc_d   = TermW'((66'(prod_c) + 66'(jitl_pkg::RoundHalf)) >>> jitl_pkg::FracW);
    tk_d   = TermW'((66'(prod_k) + 66'(jitl_pkg::RoundHalf)) >>> jitl_pkg::FracW);
    td_d   = TermW'((66'(prod_d) + 66'(jitl_pkg::RoundHalf)) >>> jitl_pkg::FracW);
  end

  // ---------------- stage 2 logic: torque sum
  always_comb begin
    sum   = SumW'(s2_tc_q) + SumW'(s2_tk_q) + SumW'(s2_td_q);
    tau_d = jitl_pkg::sat32(66'(sum));
  end

  // ---------------- stage 3 logic: rate limit
  always_comb begin
    diff = 33'(s3_tau_q) - 33'(s3_last_q);
    step = $signed({2'b00, max_torque_step_q});
    if (diff > step) begin
      diff_c = step;
    end else if (diff < -step) begin
      diff_c = -step;
    end else begin
      diff_c = diff;
    end
    cmd_d = jitl_pkg::sat32(66'(34'(s3_last_q) + 34'(diff_c)));
  end

  // ---------------- control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coriolis_scale_q  <= jitl_pkg::CoriolisScaleRst;
      max_torque_step_q <= jitl_pkg::MaxTorqueStepRst;
      impedance_off_q   <= 1'b0;
      target_seen_q     <= 1'b0;
      for (int i = 0; i < jitl_pkg::NUM_JOINTS; i++) begin
        fv_q[i]  <= 32'sd0;
        tgt_q[i] <= 32'sd0;
      end
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (jitl_pkg::cfg_reg_e'(cfg_index_i))
          jitl_pkg::CfgCoriolisScale: coriolis_scale_q  <= cfg_data_i;
          jitl_pkg::CfgMaxTorqueStep: max_torque_step_q <= cfg_data_i[jitl_pkg::StepW-1:0];
          jitl_pkg::CfgImpedanceOff:  impedance_off_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (adv) begin
        if (s0_valid_q && s0_jok) begin
          if (s0_req_q == jitl_pkg::ReqTarget) begin
            tgt_q[s0_idx] <= s0_tgt_q;
            target_seen_q <= 1'b1;
          end else begin
            fv_q[s0_idx] <= fv_new;
          end
        end
        s0_valid_q  <= in_valid_i;
        s1_valid_q  <= s1_valid_d;
        s2_valid_q  <= s1_valid_q;
        s3_valid_q  <= s2_valid_q;
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (in_valid_i) begin
        s0_req_q   <= req_type_i;
        s0_joint_q <= joint_index_i;
        s0_tgt_q   <= target_position_i;
        s0_q_q     <= measured_position_i;
        s0_dq_q    <= measured_velocity_i;
        s0_qref_q  <= reference_position_i;
        s0_dqref_q <= reference_velocity_i;
        s0_cor_q   <= coriolis_torque_i;
        s0_last_q  <= last_desired_torque_i;
        s0_k_q     <= stiffness_gain_i;
        s0_d_q     <= damping_gain_i;
      end
      s1_joint_q  <= s0_joint_q;
      s1_ep_q     <= ep_d;
      s1_ev_q     <= ev_d;
      s1_cor_q    <= s0_cor_q;
      s1_last_q   <= s0_last_q;
      s1_k_q      <= k_d;
      s1_d_q      <= d_d;
      s2_joint_q  <= s1_joint_q;
      s2_tc_q     <= tc_d;
      s2_tk_q     <= tk_d;
      s2_td_q     <= td_d;
      s2_last_q   <= s1_last_q;
      s3_joint_q  <= s2_joint_q;
      s3_tau_q    <= tau_d;
      s3_last_q   <= s2_last_q;
      out_joint_q <= s3_joint_q;
      out_tau_q   <= cmd_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_joint_o   = out_joint_q;
  assign torque_command_o = out_tau_q;

endmodule

[rtl/jitl_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for joint_impedance_torque_law, bound to the top level.
// Depends on jitl_pkg.
module jitl_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_ready_o,
  input  logic                           in_ready_o,
  input  logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [jitl_pkg::JointW-1:0]    result_joint_o,
  input  logic signed [31:0]             torque_command_o
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(torque_command_o)
      && $stable(result_joint_o))
    else $error("result item changed while stalled");

  // results only name joints that exist
  a_joint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({2'b00, result_joint_o} < 5'(jitl_pkg::NUM_JOINTS)))
    else $error("result for a joint out of range");

  // input side stalls only under output back-pressure
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind joint_impedance_torque_law jitl_checker u_jitl_checker (.*);
